@@ hdl/idgf_pkg.sv @@
package idgf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ThrW  = 16;
  localparam int unsigned ProdW = 2 * DataW;
  localparam int unsigned SumW  = DataW + 1;
  localparam int unsigned DivSteps = DataW;

  localparam logic [ThrW-1:0] ThrReset = 16'd768;

  // Per-item context that travels beside the divider.
  typedef struct packed {
    logic             pvalid;
    logic             fuse;
    logic             wzero;
    logic             neg;
    logic             gate_ok;
    logic [DataW-1:0] pm;
    logic [DataW-1:0] mm;
    logic [DataW-1:0] mv;
  } side_t;

  // State of the two restoring dividers that share one divisor.
  // The nq field holds the dividend bits still to come at the top and the
  // quotient bits already found at the bottom.
  typedef struct packed {
    logic [SumW-1:0]  w;
    logic [SumW-1:0]  rem_a;
    logic [DataW-1:0] nq_a;
    logic [SumW-1:0]  rem_b;
    logic [DataW-1:0] nq_b;
  } div_t;

endpackage

@@ hdl/idgf_front.sv @@
module idgf_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [idgf_pkg::ThrW-1:0]   thr_i,
  input  logic signed [31:0]          pred_mean_i,
  input  logic [31:0]                 pred_variance_i,
  input  logic                        pred_valid_i,
  input  logic signed [31:0]          meas_mean_i,
  input  logic [31:0]                 meas_variance_i,
  output logic                        vld_o,
  output idgf_pkg::side_t             side_o,
  output idgf_pkg::div_t              div_o
);

  localparam int unsigned DW = idgf_pkg::DataW;
  localparam int unsigned PW = idgf_pkg::ProdW;
  localparam int unsigned SW = idgf_pkg::SumW;

  // Stage 1: difference and variance sum.
  logic          v1_q;
  logic          pvalid1_q, fuse1_q;
  logic [DW-1:0] pm1_q, pv1_q, mm1_q, mv1_q;
  logic [idgf_pkg::ThrW-1:0] thr1_q;
  logic [SW-1:0] w1_q, d1_q;

  // Stage 2: magnitude of the residual and the squared threshold.
  logic          v2_q;
  logic          pvalid2_q, fuse2_q, neg2_q;
  logic [DW-1:0] pm2_q, pv2_q, mm2_q, mv2_q, mag2_q, tt2_q;
  logic [SW-1:0] w2_q, negd2;

  // Stage 3: products.
  logic          v3_q;
  logic          pvalid3_q, fuse3_q, neg3_q;
  logic [DW-1:0] pm3_q, mm3_q, mv3_q;
  logic [SW-1:0] w3_q;
  logic [PW-1:0] pa3_q, pb3_q, rr3_q, ttpv3_q;

  assign negd2 = SW'(0) - d1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      vld_o <= 1'b0;
    end else if (en_i) begin
      v1_q  <= vld_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      vld_o <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pvalid1_q <= pred_valid_i;
      fuse1_q   <= pred_valid_i && !pred_mean_i[DW-1] && (pred_mean_i != '0);
      pm1_q     <= pred_mean_i;
      pv1_q     <= pred_variance_i;
      mm1_q     <= meas_mean_i;
      mv1_q     <= meas_variance_i;
      thr1_q    <= thr_i;
      w1_q      <= {1'b0, pred_variance_i} + {1'b0, meas_variance_i};
      d1_q      <= {meas_mean_i[DW-1], meas_mean_i} - {pred_mean_i[DW-1], pred_mean_i};

      pvalid2_q <= pvalid1_q;
      fuse2_q   <= fuse1_q;
      neg2_q    <= d1_q[SW-1];
      pm2_q     <= pm1_q;
      pv2_q     <= pv1_q;
      mm2_q     <= mm1_q;
      mv2_q     <= mv1_q;
      w2_q      <= w1_q;
      // The residual magnitude never exceeds 2^32 - 1.
      mag2_q    <= d1_q[SW-1] ? negd2[DW-1:0] : d1_q[DW-1:0];
      tt2_q     <= DW'(thr1_q) * DW'(thr1_q);

      pvalid3_q <= pvalid2_q;
      fuse3_q   <= fuse2_q;
      neg3_q    <= neg2_q;
      pm3_q     <= pm2_q;
      mm3_q     <= mm2_q;
      mv3_q     <= mv2_q;
      w3_q      <= w2_q;
      pa3_q     <= PW'(pv2_q) * PW'(mag2_q);
      pb3_q     <= PW'(pv2_q) * PW'(mv2_q);
      rr3_q     <= PW'(mag2_q) * PW'(mag2_q);
      ttpv3_q   <= PW'(tt2_q) * PW'(pv2_q);

      side_o.pvalid  <= pvalid3_q;
      side_o.fuse    <= fuse3_q;
      side_o.wzero   <= (w3_q == '0);
      side_o.neg     <= neg3_q;
      side_o.gate_ok <= !(rr3_q > ttpv3_q);
      side_o.pm      <= pm3_q;
      side_o.mm      <= mm3_q;
      side_o.mv      <= mv3_q;
      div_o.w        <= w3_q;
      div_o.rem_a    <= {1'b0, pa3_q[PW-1:DW]};
      div_o.nq_a     <= pa3_q[DW-1:0];
      div_o.rem_b    <= {1'b0, pb3_q[PW-1:DW]};
      div_o.nq_b     <= pb3_q[DW-1:0];
    end
  end

endmodule

@@ hdl/idgf_div_step.sv @@
module idgf_div_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  idgf_pkg::side_t side_i,
  input  idgf_pkg::div_t  div_i,
  output logic            vld_o,
  output idgf_pkg::side_t side_o,
  output idgf_pkg::div_t  div_o
);

  localparam int unsigned DW = idgf_pkg::DataW;
  localparam int unsigned SW = idgf_pkg::SumW;

  logic [SW:0]   ta, tb, wx, da, db;
  logic          ge_a, ge_b;
  idgf_pkg::div_t div_d;

  always_comb begin
    wx   = {1'b0, div_i.w};
    ta   = {div_i.rem_a, div_i.nq_a[DW-1]};
    tb   = {div_i.rem_b, div_i.nq_b[DW-1]};
    ge_a = (ta >= wx);
    ge_b = (tb >= wx);
    da   = ta - wx;
    db   = tb - wx;
    div_d.w     = div_i.w;
    div_d.rem_a = ge_a ? da[SW-1:0] : ta[SW-1:0];
    div_d.rem_b = ge_b ? db[SW-1:0] : tb[SW-1:0];
    div_d.nq_a  = {div_i.nq_a[DW-2:0], ge_a};
    div_d.nq_b  = {div_i.nq_b[DW-2:0], ge_b};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      div_o  <= div_d;
    end
  end

endmodule

@@ hdl/inverse_depth_gaussian_fusion.sv @@
// The result is registered at the outputs after the front stages and the divider steps.
// Throughput: one transaction per cycle while in_stall_o is low; the 32 one-bit steps of the
// shared-divisor restoring divider each occupy a pipeline stage.
// A two-entry output buffer decouples the sides; in_stall_o is a registered flag.
// Reset (rst_ni low, asynchronous) empties the pipeline and sets the threshold to 3.0.
module inverse_depth_gaussian_fusion (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [31:0]   pred_mean_i,
  input  logic [31:0]          pred_variance_i,
  input  logic                 pred_valid_i,
  input  logic signed [31:0]   meas_mean_i,
  input  logic [31:0]          meas_variance_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [31:0]   post_mean_o,
  output logic [31:0]          post_variance_o,
  output logic                 accepted_o
);

  localparam int unsigned DW = idgf_pkg::DataW;
  localparam int unsigned NS = idgf_pkg::DivSteps;

  logic [idgf_pkg::ThrW-1:0] thr_q;
  logic en;

  logic            vld_s [NS+1];
  idgf_pkg::side_t side_s [NS+1];
  idgf_pkg::div_t  div_s [NS+1];

  logic [DW:0]    pm_x, sum;
  logic [DW-1:0]  mu, var_r;
  logic           acc;

  logic           out_v_q, out_v_d, skid_v_q, skid_v_d;
  logic [DW-1:0]  out_mu_q, out_mu_d, out_var_q, out_var_d;
  logic           out_acc_q, out_acc_d;
  logic [DW-1:0]  skid_mu_q, skid_mu_d, skid_var_q, skid_var_d;
  logic           skid_acc_q, skid_acc_d;
  logic           out_take;

  assign cfg_ready_o = 1'b1;
  assign en          = !skid_v_q;
  assign in_stall_o  = skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= idgf_pkg::ThrReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  idgf_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .vld_i           (in_valid_i),
    .thr_i           (thr_q),
    .pred_mean_i     (pred_mean_i),
    .pred_variance_i (pred_variance_i),
    .pred_valid_i    (pred_valid_i),
    .meas_mean_i     (meas_mean_i),
    .meas_variance_i (meas_variance_i),
    .vld_o           (vld_s[0]),
    .side_o          (side_s[0]),
    .div_o           (div_s[0])
  );

  for (genvar k = 0; k < NS; k++) begin : g_div
    idgf_div_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vld_s[k]),
      .side_i (side_s[k]),
      .div_i  (div_s[k]),
      .vld_o  (vld_s[k+1]),
      .side_o (side_s[k+1]),
      .div_o  (div_s[k+1])
    );
  end

  // Final combine: when fusing, the quotient moves the prediction towards the measurement.
  always_comb begin
    pm_x = {side_s[NS].pm[DW-1], side_s[NS].pm};
    sum  = side_s[NS].neg ? pm_x - {1'b0, div_s[NS].nq_a}
                          : pm_x + {1'b0, div_s[NS].nq_a};
    if (!side_s[NS].fuse) begin
      mu    = side_s[NS].mm;
      var_r = side_s[NS].mv;
    end else if (side_s[NS].wzero) begin
      mu    = side_s[NS].mm;
      var_r = '0;
    end else begin
      mu    = sum[DW-1:0];
      var_r = div_s[NS].nq_b;
    end
    acc = !side_s[NS].pvalid || side_s[NS].gate_ok;
    if (acc && (mu[DW-1] || (mu == '0))) begin
      mu = '0;
    end
  end

  assign out_take = out_v_q && !out_stall_i;

  always_comb begin
    out_v_d    = out_v_q;
    out_mu_d   = out_mu_q;
    out_var_d  = out_var_q;
    out_acc_d  = out_acc_q;
    skid_v_d   = skid_v_q;
    skid_mu_d  = skid_mu_q;
    skid_var_d = skid_var_q;
    skid_acc_d = skid_acc_q;
    if (skid_v_q) begin
      if (out_take) begin
        out_mu_d  = skid_mu_q;
        out_var_d = skid_var_q;
        out_acc_d = skid_acc_q;
        skid_v_d  = 1'b0;
      end
    end else if (!out_v_q || out_take) begin
      out_v_d   = vld_s[NS];
      out_mu_d  = mu;
      out_var_d = var_r;
      out_acc_d = acc;
    end else if (vld_s[NS]) begin
      // Output is held; the arriving transaction waits in the skid entry.
      skid_v_d   = 1'b1;
      skid_mu_d  = mu;
      skid_var_d = var_r;
      skid_acc_d = acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_mu_q   <= out_mu_d;
    out_var_q  <= out_var_d;
    out_acc_q  <= out_acc_d;
    skid_mu_q  <= skid_mu_d;
    skid_var_q <= skid_var_d;
    skid_acc_q <= skid_acc_d;
  end

  assign out_valid_o     = out_v_q;
  assign post_mean_o     = out_mu_q;
  assign post_variance_o = out_var_q;
  assign accepted_o      = out_acc_q;

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid entry full while output empty");
  a_held_out_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_stall_i |=> out_v_q) else $error("held result lost");
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !out_stall_i |=> !skid_v_q) else $error("skid entry not drained");
  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> in_stall_o) else $error("input taken while skid full");
`endif

endmodule
